// ===== design/swdr_pkg.sv =====
// Package for the stepper wave-drive ramp block: types, register indexes and
// numeric constants. It has no dependencies and is compiled first.
package swdr_pkg;

    // Field and register widths.
    localparam int SPEED_W  = 14;
    localparam int SPR_W    = 13;
    localparam int ACCEL_W  = 16;
    localparam int MS_W     = 24;
    localparam int DELAY_W  = 32;
    localparam int CFG_W    = 16;

    // Datapath widths.
    localparam int D_W      = SPEED_W + SPR_W;       // speed times steps per rev
    localparam int LIM_W    = ACCEL_W + MS_W + 1;    // ramp end bound
    localparam int FAST_W   = 31;                    // fast-end delay
    localparam int SLOW_W   = 30;                    // slow-end delay
    localparam int DIFF_W   = 32;                    // signed span of the ramp
    localparam int PROD_W   = 56;                    // elapsed times span
    localparam int QUO_W    = 32;                    // divider quotient bits
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Numeric constants.
    localparam logic [LIM_W-1:0]  MIN_DELAY_US = LIM_W'(50);
    localparam logic [QUO_W-1:0]  FAST_NUM     = QUO_W'(1600000000);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SPEED = 2'd0,
        CFG_SPR   = 2'd1,
        CFG_ACCEL = 2'd2
    } cfg_idx_t;

    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(960);
    localparam logic [SPR_W-1:0]   SPR_RESET   = SPR_W'(200);
    localparam logic [ACCEL_W-1:0] ACCEL_RESET = ACCEL_W'(500);

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD1,
        ST_DIV1,
        ST_BOUND,
        ST_MUL,
        ST_LOAD2,
        ST_DIV2,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic calc;
        logic div_load1;
        logic div_load2;
        logic div_step;
        logic bound;
        logic mul;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done_flag;
        logic div_last;
    } status_t;

endpackage

// ===== design/swdr_div.sv =====
// Serial restoring divider, one quotient bit per cycle while step is asserted;
// last flags the final step. Depends on swdr_pkg for widths.
module swdr_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         step,
    input  logic [swdr_pkg::D_W-1:0]     rem_init,
    input  logic [swdr_pkg::QUO_W-1:0]   quo_init,
    input  logic [swdr_pkg::D_W-1:0]     dvs_init,
    output logic [swdr_pkg::QUO_W-1:0]   quo,
    output logic                         last
);

    logic [swdr_pkg::D_W-1:0]       rem_reg, rem_next;
    logic [swdr_pkg::QUO_W-1:0]     quo_reg, quo_next;
    logic [swdr_pkg::D_W-1:0]       dvs_reg, dvs_next;
    logic [swdr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [swdr_pkg::D_W:0]         trial;
    logic [swdr_pkg::D_W:0]         sub;
    logic                           fits;

    // The remainder stays below the divisor, so the shifted trial fits in
    // one extra bit.
    assign trial = {rem_reg, quo_reg[swdr_pkg::QUO_W-1]};
    assign sub   = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            rem_next = rem_init;
            quo_next = quo_init;
            dvs_next = dvs_init;
            cnt_next = '0;
        end
        else if (step)
        begin
            rem_next = fits ? sub[swdr_pkg::D_W-1:0] : trial[swdr_pkg::D_W-1:0];
            quo_next = {quo_reg[swdr_pkg::QUO_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quo  = quo_reg;
    assign last = (cnt_reg == swdr_pkg::DIV_CNT_W'(swdr_pkg::QUO_W - 1));

endmodule

// ===== design/swdr_dpath.sv =====
// Datapath of the stepper wave-drive ramp: configuration registers, ramp
// arithmetic, phase register and output payload. Depends on swdr_pkg, swdr_div.
module swdr_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swdr_pkg::cmd_t                      cmd,
    output swdr_pkg::status_t                   status,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [swdr_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                direction,
    input  logic [swdr_pkg::MS_W-1:0]           elapsed_ms,
    input  logic [swdr_pkg::MS_W-1:0]           duration_ms,
    output logic [3:0]                          coils,
    output logic signed [swdr_pkg::DELAY_W-1:0] step_delay_us,
    output logic                                done_res
);

    logic [swdr_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic [swdr_pkg::SPR_W-1:0]   spr_reg, spr_next;
    logic [swdr_pkg::ACCEL_W-1:0] accel_reg, accel_next;
    logic [1:0]                   phase_reg, phase_next;

    logic                         dir_reg;
    logic [swdr_pkg::MS_W-1:0]    el_reg;
    logic [swdr_pkg::MS_W-1:0]    du_reg;
    logic                         done_reg;
    logic [swdr_pkg::D_W-1:0]     d_reg;
    logic [swdr_pkg::LIM_W-1:0]   lim_reg;
    logic [swdr_pkg::SLOW_W-1:0]  a_reg;
    logic signed [swdr_pkg::DIFF_W-1:0] diff_reg;
    logic signed [swdr_pkg::PROD_W-1:0] prod_reg;
    logic                         neg_reg;
    logic [3:0]                   coils_reg;
    logic signed [swdr_pkg::DELAY_W-1:0] delay_reg;
    logic                         done_out_reg;

    logic [swdr_pkg::D_W-1:0]     d_prod;
    logic [swdr_pkg::LIM_W-1:0]   lim_calc;
    logic [swdr_pkg::FAST_W-1:0]  fast;
    logic [swdr_pkg::SLOW_W-1:0]  slow;
    logic [swdr_pkg::SLOW_W-1:0]  a_calc;
    logic [swdr_pkg::FAST_W-1:0]  b_calc;
    logic signed [swdr_pkg::DIFF_W-1:0] diff_calc;
    logic signed [swdr_pkg::PROD_W:0]   prod_full;
    logic [swdr_pkg::PROD_W-1:0]  mag;
    logic [swdr_pkg::QUO_W-1:0]   quo;
    logic                         div_last;
    logic [swdr_pkg::D_W-1:0]     rem_init;
    logic [swdr_pkg::QUO_W-1:0]   quo_init;
    logic [swdr_pkg::D_W-1:0]     dvs_init;
    logic signed [swdr_pkg::DELAY_W-1:0] q_signed;
    logic [3:0]                   coil_sel;

    // Configuration writes; an index beyond the list is ignored.
    always_comb
    begin
        speed_next = speed_reg;
        spr_next   = spr_reg;
        accel_next = accel_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                swdr_pkg::CFG_SPEED: speed_next = cfg_data[swdr_pkg::SPEED_W-1:0];
                swdr_pkg::CFG_SPR:   spr_next   = cfg_data[swdr_pkg::SPR_W-1:0];
                swdr_pkg::CFG_ACCEL: accel_next = cfg_data[swdr_pkg::ACCEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Divisor for the speed division and the ramp end bound.
    assign d_prod   = speed_reg * spr_reg;
    assign lim_calc = swdr_pkg::MIN_DELAY_US
                    + accel_reg * (swdr_pkg::LIM_W'(du_reg) - swdr_pkg::LIM_W'(el_reg));

    // The slow-end delay is half the fast-end quotient, rounded down.
    assign fast   = quo[swdr_pkg::FAST_W-1:0];
    assign slow   = fast[swdr_pkg::FAST_W-1:1];
    assign a_calc = (swdr_pkg::LIM_W'(slow) > swdr_pkg::MIN_DELAY_US)
                  ? slow : swdr_pkg::SLOW_W'(swdr_pkg::MIN_DELAY_US);
    assign b_calc = (swdr_pkg::LIM_W'(fast) < lim_reg)
                  ? fast : lim_reg[swdr_pkg::FAST_W-1:0];
    assign diff_calc = $signed({1'b0, b_calc}) - $signed({2'b00, a_calc});

    assign prod_full = $signed({1'b0, el_reg}) * diff_reg;

    // Divide the magnitude and restore the sign, which truncates toward zero.
    // The magnitude is below the divisor times 2^31, so its top bits start
    // the remainder.
    assign mag = neg_reg ? swdr_pkg::PROD_W'(-prod_reg) : swdr_pkg::PROD_W'(prod_reg);

    always_comb
    begin
        if (cmd.div_load2)
        begin
            rem_init = swdr_pkg::D_W'(mag[swdr_pkg::PROD_W-1:swdr_pkg::QUO_W]);
            quo_init = mag[swdr_pkg::QUO_W-1:0];
            dvs_init = swdr_pkg::D_W'(du_reg);
        end
        else
        begin
            rem_init = '0;
            quo_init = swdr_pkg::FAST_NUM;
            dvs_init = d_reg;
        end
    end

    swdr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load1 | cmd.div_load2),
        .step     (cmd.div_step),
        .rem_init (rem_init),
        .quo_init (quo_init),
        .dvs_init (dvs_init),
        .quo      (quo),
        .last     (div_last)
    );

    assign q_signed = neg_reg ? -$signed(quo) : $signed(quo);

    // Forward order drives bit p, backward order drives bit 3-p.
    assign coil_sel = dir_reg ? (4'b0001 << phase_reg) : (4'b0001 << ~phase_reg);

    always_comb
    begin
        phase_next = phase_reg;
        if (cmd.load_out && !done_reg)
        begin
            phase_next = phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= swdr_pkg::SPEED_RESET;
            spr_reg   <= swdr_pkg::SPR_RESET;
            accel_reg <= swdr_pkg::ACCEL_RESET;
            phase_reg <= 2'd0;
        end
        else
        begin
            speed_reg <= speed_next;
            spr_reg   <= spr_next;
            accel_reg <= accel_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dir_reg  <= direction;
            el_reg   <= elapsed_ms;
            du_reg   <= duration_ms;
            done_reg <= (elapsed_ms >= duration_ms);
        end
        if (cmd.calc)
        begin
            d_reg   <= (d_prod == '0) ? swdr_pkg::D_W'(1) : d_prod;
            lim_reg <= lim_calc;
        end
        if (cmd.bound)
        begin
            a_reg    <= a_calc;
            diff_reg <= diff_calc;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[swdr_pkg::PROD_W-1:0];
            neg_reg  <= prod_full[swdr_pkg::PROD_W];
        end
        if (cmd.load_out)
        begin
            if (done_reg)
            begin
                coils_reg    <= 4'b0000;
                delay_reg    <= '0;
                done_out_reg <= 1'b1;
            end
            else
            begin
                coils_reg    <= coil_sel;
                delay_reg    <= $signed({2'b00, a_reg}) + q_signed;
                done_out_reg <= 1'b0;
            end
        end
    end

    assign status.done_flag = done_reg;
    assign status.div_last  = div_last;

    assign coils         = coils_reg;
    assign step_delay_us = delay_reg;
    assign done_res      = done_out_reg;

endmodule

// ===== design/swdr_ctrl.sv =====
// Controller state machine of the stepper wave-drive ramp: sequences the
// datapath and owns both handshakes. Depends on swdr_pkg.
module swdr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  swdr_pkg::status_t status,
    output swdr_pkg::cmd_t    cmd
);

    swdr_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swdr_pkg::ST_IDLE:  if (in_valid) state_next = swdr_pkg::ST_PREP;
            swdr_pkg::ST_PREP:  state_next = status.done_flag ? swdr_pkg::ST_FIN
                                                              : swdr_pkg::ST_LOAD1;
            swdr_pkg::ST_LOAD1: state_next = swdr_pkg::ST_DIV1;
            swdr_pkg::ST_DIV1:  if (status.div_last) state_next = swdr_pkg::ST_BOUND;
            swdr_pkg::ST_BOUND: state_next = swdr_pkg::ST_MUL;
            swdr_pkg::ST_MUL:   state_next = swdr_pkg::ST_LOAD2;
            swdr_pkg::ST_LOAD2: state_next = swdr_pkg::ST_DIV2;
            swdr_pkg::ST_DIV2:  if (status.div_last) state_next = swdr_pkg::ST_FIN;
            swdr_pkg::ST_FIN:   if (out_free) state_next = swdr_pkg::ST_IDLE;
            default:            state_next = swdr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            swdr_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            swdr_pkg::ST_PREP:  cmd.calc      = 1'b1;
            swdr_pkg::ST_LOAD1: cmd.div_load1 = 1'b1;
            swdr_pkg::ST_DIV1:  cmd.div_step  = 1'b1;
            swdr_pkg::ST_BOUND: cmd.bound     = 1'b1;
            swdr_pkg::ST_MUL:   cmd.mul       = 1'b1;
            swdr_pkg::ST_LOAD2: cmd.div_load2 = 1'b1;
            swdr_pkg::ST_DIV2:  cmd.div_step  = 1'b1;
            swdr_pkg::ST_FIN:   cmd.load_out  = out_free;
            default:            cmd           = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swdr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/stepper_wave_drive_ramp.sv =====
// A new item is accepted only once the previous one has been loaded into the
// output register. Each step item runs the shared serial divider twice, once
// for the speed division and once for the ramp division; an item that reports
// the move as done skips both. Reset (rst_n, asynchronous, active low) clears
// the phase and the handshakes and loads speed 960, 200 steps/rev, accel 500.
// Top level: ties swdr_ctrl to swdr_dpath. Depends on swdr_pkg.
module stepper_wave_drive_ramp (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [swdr_pkg::CFG_W-1:0]          cfg_data,
    // Input item channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                direction,
    input  logic [swdr_pkg::MS_W-1:0]           elapsed_ms,
    input  logic [swdr_pkg::MS_W-1:0]           duration_ms,
    // Result item channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [3:0]                          coils,
    output logic signed [swdr_pkg::DELAY_W-1:0] step_delay_us,
    output logic                                done_res
);

    // The controller steps through the phases of one item: capture the
    // inputs, form the speed divisor and the ramp end bound, run the divider
    // for the fast-end delay, clamp the two ramp ends, multiply by the
    // elapsed time, run the divider again over the duration, and finally load
    // the output register. The output register holds a finished item while
    // the block already accepts and works on the next one; the controller
    // only waits in its last state if the previous item is still stalled.
    swdr_pkg::cmd_t    cmd;
    swdr_pkg::status_t status;

    swdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath keeps the configuration registers and the coil phase.
    // The phase advances by one for every step item, whatever the direction.
    swdr_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .direction     (direction),
        .elapsed_ms    (elapsed_ms),
        .duration_ms   (duration_ms),
        .coils         (coils),
        .step_delay_us (step_delay_us),
        .done_res      (done_res)
    );

endmodule
